/* src/boid_box_neighbor_average_top_assert.svh */
// ----------------------------------------------------------------------------
// Boid neighbor average assertion macros
// Clocked concurrent checks on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOID_BOX_NEIGHBOR_AVERAGE_TOP_ASSERT_SVH
`define BOID_BOX_NEIGHBOR_AVERAGE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BBNA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define BBNA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BBNA_ASSERT_IMP(lbl, ante, cons)
`define BBNA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* src/bbna_pkg.sv */
// ----------------------------------------------------------------------------
// bbna_pkg
// Widths, state codes and handshake structs of the boid neighbor averager.
// ----------------------------------------------------------------------------
package bbna_pkg;

	localparam int MAX_NEIGHBORS = 64;
	localparam int POS_W         = 32;
	localparam int ID_W          = 16;
	localparam int RANGE_W       = 31;
	localparam int NCOUNT_W      = 7;
	localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
	localparam int DVS_W         = $clog2(MAX_NEIGHBORS + 2);
	localparam int SUM_W         = POS_W + CNT_W;
	localparam int BOX_W         = POS_W + 1;
	localparam int ITER_W        = $clog2(SUM_W + 1);
	localparam int NVAL          = 4;
	localparam int IDX_W         = $clog2(NVAL);
	localparam int IN_TDATA_W    = ((ID_W + NVAL * POS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W   = ((NVAL * POS_W + NCOUNT_W + 7) / 8) * 8;
	localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(655360);

	localparam logic KIND_OWN  = 1'b0;
	localparam logic KIND_CAND = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EVAL = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [POS_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* src/bbna_div.sv */
// ----------------------------------------------------------------------------
// bbna_div
// Shared signed divider, restoring, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`include "boid_box_neighbor_average_top_assert.svh"

module bbna_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bbna_pkg::div_cmd_t cmd,
	output bbna_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic                          neg_q;
	logic [bbna_pkg::SUM_W-1:0]    quo_q;
	logic [bbna_pkg::DVS_W-1:0]    rem_q;
	logic [bbna_pkg::DVS_W-1:0]    dvs_q;
	logic [bbna_pkg::ITER_W-1:0]   cnt_q;
	logic [bbna_pkg::SUM_W-1:0]    mag;
	logic [bbna_pkg::DVS_W:0]      trial;
	logic [bbna_pkg::DVS_W:0]      diff;
	logic                          ge;
	logic [bbna_pkg::DVS_W-1:0]    rem_nxt;
	logic [bbna_pkg::SUM_W-1:0]    quo_full;

	assign mag     = cmd.dividend[bbna_pkg::SUM_W-1] ? (~cmd.dividend + 1'b1) : cmd.dividend;
	assign trial   = {rem_q, quo_q[bbna_pkg::SUM_W-1]};
	assign ge      = trial >= {1'b0, dvs_q};
	assign diff    = trial - {1'b0, dvs_q};
	// remainder stays below the divisor, so the top bit drops out
	assign rem_nxt = ge ? diff[bbna_pkg::DVS_W-1:0] : trial[bbna_pkg::DVS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= bbna_pkg::ITER_W'(bbna_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bbna_pkg::ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= cmd.divisor;
			neg_q <= cmd.dividend[bbna_pkg::SUM_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[bbna_pkg::SUM_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quo_full     = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_full[bbna_pkg::POS_W-1:0];

	`BBNA_ASSERT_IMP(a_no_restart, cmd.start, !busy_q)
	`BBNA_ASSERT_NXT(a_start_busy, cmd.start, busy_q)
	`BBNA_ASSERT_IMP(a_idle_cnt_zero, !busy_q, cnt_q == '0)

endmodule

/* src/bbna_box.sv */
// ----------------------------------------------------------------------------
// bbna_box
// Neighbor test: different id and strictly inside the box on both axes.
// ----------------------------------------------------------------------------
module bbna_box (
	input  logic [bbna_pkg::ID_W-1:0]    own_id,
	input  logic [bbna_pkg::POS_W-1:0]   own_x,
	input  logic [bbna_pkg::POS_W-1:0]   own_y,
	input  logic [bbna_pkg::RANGE_W-1:0] range_val,
	input  logic [bbna_pkg::ID_W-1:0]    cand_id,
	input  logic [bbna_pkg::POS_W-1:0]   cand_x,
	input  logic [bbna_pkg::POS_W-1:0]   cand_y,
	output logic                         hit
);

	logic signed [bbna_pkg::BOX_W-1:0] rng;
	logic signed [bbna_pkg::BOX_W-1:0] ox, oy, cx, cy;
	logic signed [bbna_pkg::BOX_W-1:0] lo_x, hi_x, lo_y, hi_y;

	// bounds are one bit wider than positions
	assign rng  = signed'({2'b00, range_val});
	assign ox   = signed'({own_x[bbna_pkg::POS_W-1], own_x});
	assign oy   = signed'({own_y[bbna_pkg::POS_W-1], own_y});
	assign cx   = signed'({cand_x[bbna_pkg::POS_W-1], cand_x});
	assign cy   = signed'({cand_y[bbna_pkg::POS_W-1], cand_y});
	assign lo_x = ox - rng;
	assign hi_x = ox + rng;
	assign lo_y = oy - rng;
	assign hi_y = oy + rng;

	assign hit = (cand_id != own_id) && (cx > lo_x) && (cx < hi_x)
	             && (cy > lo_y) && (cy < hi_y);

endmodule

/* src/boid_box_neighbor_average_top.sv */
// ----------------------------------------------------------------------------
// boid_box_neighbor_average_top
// Boid neighbor averaging: box test, running sums, shared divider.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser = kind (0 loads own boid and seeds the sums,
// 1 is a candidate), tlast ends a set. Each request is registered and
// evaluated in the next cycle. A request with tlast yields one result on
// m_*; if there are neighbors, the four sums first run one after another
// through one restoring divider. s_tready is low while a request is in
// work. The result sits in an output register, so a new request is taken
// while it waits; if the receiver still holds the previous result when
// the next one is ready, the sequencer waits.
// range_we writes the box half-width; write only while idle.
// Reset clears own boid, sums, count and flag to zero and range to 10.0.
// ----------------------------------------------------------------------------
`include "boid_box_neighbor_average_top_assert.svh"

module boid_box_neighbor_average_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                range_we,
	input  logic [bbna_pkg::RANGE_W-1:0]        range_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// boid_id, pos_x, pos_y, vel_x, vel_y
	input  logic [bbna_pkg::IN_TDATA_W-1:0]     s_tdata,
	// kind
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y, neighbor_count, zero pad
	output logic [bbna_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// dropped
	output logic                                m_tuser
);

	bbna_pkg::state_t                  state_q;
	logic [bbna_pkg::RANGE_W-1:0]      range_q;
	logic                              kind_q;
	logic                              last_q;
	logic [bbna_pkg::ID_W-1:0]         id_q;
	logic [bbna_pkg::POS_W-1:0]        val_q  [bbna_pkg::NVAL];
	logic [bbna_pkg::ID_W-1:0]         own_id_q;
	logic [bbna_pkg::POS_W-1:0]        own_q  [bbna_pkg::NVAL];
	logic [bbna_pkg::SUM_W-1:0]        sum_q  [bbna_pkg::NVAL];
	logic [bbna_pkg::CNT_W-1:0]        count_q;
	logic                              ovf_q;
	logic [bbna_pkg::IDX_W-1:0]        idx_q;
	logic                              hit;
	logic                              room;
	logic                              take;
	logic [bbna_pkg::CNT_W-1:0]        count_nxt;
	logic                              out_free;
	bbna_pkg::div_cmd_t                div_cmd;
	bbna_pkg::div_rsp_t                div_rsp;

	assign s_tready = state_q == bbna_pkg::ST_IDLE;
	assign out_free = !m_tvalid || m_tready;

	bbna_box u_box (
		.own_id    (own_id_q),
		.own_x     (own_q[0]),
		.own_y     (own_q[1]),
		.range_val (range_q),
		.cand_id   (id_q),
		.cand_x    (val_q[0]),
		.cand_y    (val_q[1]),
		.hit       (hit)
	);

	assign room      = count_q < bbna_pkg::CNT_W'(bbna_pkg::MAX_NEIGHBORS);
	assign take      = (kind_q == bbna_pkg::KIND_CAND) && hit && room;
	assign count_nxt = (kind_q == bbna_pkg::KIND_OWN) ? '0
	                   : count_q + bbna_pkg::CNT_W'(take);

	assign div_cmd.start    = state_q == bbna_pkg::ST_DIV;
	assign div_cmd.dividend = sum_q[idx_q];
	assign div_cmd.divisor  = bbna_pkg::DVS_W'(count_q) + bbna_pkg::DVS_W'(1);

	bbna_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= bbna_pkg::RANGE_RESET;
		end else if (range_we) begin
			range_q <= range_wdata;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			last_q <= s_tlast;
			id_q   <= s_tdata[bbna_pkg::ID_W-1:0];
			for (int i = 0; i < bbna_pkg::NVAL; i++) begin
				val_q[i] <= s_tdata[bbna_pkg::ID_W + i*bbna_pkg::POS_W +: bbna_pkg::POS_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bbna_pkg::ST_IDLE;
			idx_q    <= '0;
			own_id_q <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			m_tvalid <= 1'b0;
			for (int i = 0; i < bbna_pkg::NVAL; i++) begin
				own_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else begin
			if (state_q == bbna_pkg::ST_DONE && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				bbna_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= bbna_pkg::ST_EVAL;
					end
				end
				bbna_pkg::ST_EVAL: begin
					if (kind_q == bbna_pkg::KIND_OWN) begin
						own_id_q <= id_q;
						ovf_q    <= 1'b0;
						for (int i = 0; i < bbna_pkg::NVAL; i++) begin
							own_q[i] <= val_q[i];
							sum_q[i] <= {{(bbna_pkg::SUM_W-bbna_pkg::POS_W)
							             {val_q[i][bbna_pkg::POS_W-1]}}, val_q[i]};
						end
					end else if (hit) begin
						if (room) begin
							for (int i = 0; i < bbna_pkg::NVAL; i++) begin
								sum_q[i] <= sum_q[i] + {{(bbna_pkg::SUM_W-bbna_pkg::POS_W)
								            {val_q[i][bbna_pkg::POS_W-1]}}, val_q[i]};
							end
						end else begin
							ovf_q <= 1'b1;
						end
					end
					count_q <= count_nxt;
					idx_q   <= '0;
					if (!last_q) begin
						state_q <= bbna_pkg::ST_IDLE;
					end else if (count_nxt != '0) begin
						state_q <= bbna_pkg::ST_DIV;
					end else begin
						state_q <= bbna_pkg::ST_DONE;
					end
				end
				bbna_pkg::ST_DIV: begin
					state_q <= bbna_pkg::ST_WAIT;
				end
				bbna_pkg::ST_WAIT: begin
					if (div_rsp.done) begin
						own_q[idx_q] <= div_rsp.quotient;
						idx_q        <= idx_q + 1'b1;
						if (idx_q == bbna_pkg::IDX_W'(bbna_pkg::NVAL - 1)) begin
							state_q <= bbna_pkg::ST_DONE;
						end else begin
							state_q <= bbna_pkg::ST_DIV;
						end
					end
				end
				bbna_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= bbna_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= bbna_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == bbna_pkg::ST_DONE && out_free) begin
			m_tdata <= {{(bbna_pkg::OUT_TDATA_W - bbna_pkg::NVAL*bbna_pkg::POS_W
			             - bbna_pkg::NCOUNT_W){1'b0}},
			            bbna_pkg::NCOUNT_W'(count_q),
			            own_q[3], own_q[2], own_q[1], own_q[0]};
			m_tuser <= ovf_q;
		end
	end

	`BBNA_ASSERT_NXT(a_accept_eval, s_tvalid && s_tready, state_q == bbna_pkg::ST_EVAL)
	`BBNA_ASSERT_IMP(a_done_in_wait, div_rsp.done, state_q == bbna_pkg::ST_WAIT)
	`BBNA_ASSERT_IMP(a_busy_in_wait, div_rsp.busy, state_q == bbna_pkg::ST_WAIT)
	`BBNA_ASSERT_IMP(a_count_cap, 1'b1, count_q <= bbna_pkg::CNT_W'(bbna_pkg::MAX_NEIGHBORS))

endmodule

/* sim/boid_box_neighbor_average_top_tb.sv */
// ----------------------------------------------------------------------------
// boid_box_neighbor_average_top_tb
// Self-checking bench for the boid neighbor averager. A directed table and
// random flock sets are streamed in under several box ranges, with bursty
// input and a stalling receiver; every result is compared field by field
// against typed rows or an in-bench model: box test, running sums, averaging.
// ----------------------------------------------------------------------------
module boid_box_neighbor_average_top_tb;

	localparam int ID_W          = bbna_pkg::ID_W;
	localparam int POS_W         = bbna_pkg::POS_W;
	localparam int RANGE_W       = bbna_pkg::RANGE_W;
	localparam int NCOUNT_W      = bbna_pkg::NCOUNT_W;
	localparam int IN_TDATA_W    = bbna_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W   = bbna_pkg::OUT_TDATA_W;
	localparam int MAX_NEIGHBORS = bbna_pkg::MAX_NEIGHBORS;
	localparam logic KIND_OWN    = bbna_pkg::KIND_OWN;
	localparam logic KIND_CAND   = bbna_pkg::KIND_CAND;
	localparam logic [RANGE_W-1:0] RANGE_RESET = bbna_pkg::RANGE_RESET;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   id;
		logic [POS_W-1:0]  px;
		logic [POS_W-1:0]  py;
		logic [POS_W-1:0]  vx;
		logic [POS_W-1:0]  vy;
		logic              last;
	} boid_item_t;

	typedef struct packed {
		logic [POS_W-1:0]    npx;
		logic [POS_W-1:0]    npy;
		logic [POS_W-1:0]    nvx;
		logic [POS_W-1:0]    nvy;
		logic [NCOUNT_W-1:0] cnt;
		logic                dropped;
	} boid_result_t;

	typedef struct packed {
		boid_item_t   it;
		logic         typed;
		boid_result_t want;
	} dir_row_t;

	localparam logic [POS_W-1:0] PMAX = 32'h7FFF_FFFF;
	localparam logic [POS_W-1:0] PMIN = 32'h8000_0000;
	localparam int N_DIR = 20;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int PEND_DEPTH = 64;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   range_we = 1'b0;
	logic [RANGE_W-1:0]     range_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	always #1 clk = ~clk;

	boid_box_neighbor_average_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.range_we    (range_we),
		.range_wdata (range_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	// directed rows; typed expectations only where obvious, rest predicted
	dir_row_t dir_rows [N_DIR] = '{
		// candidate before any load, same id as reset own boid
		'{'{KIND_CAND, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1}, 1'b1,
			'{32'd0, 32'd0, 32'd0, 32'd0, 7'd0, 1'b0}},
		// candidate before any load, neighbor of the zero own boid
		'{'{KIND_CAND, 16'd3, 32'd1, 32'd1, 32'd100, -32'sd100, 1'b1}, 1'b0, '0},
		// load with last: own values straight back
		'{'{KIND_OWN, 16'd7, PMAX, PMIN, PMIN, PMAX, 1'b1}, 1'b1,
			'{PMAX, PMIN, PMIN, PMAX, 7'd0, 1'b0}},
		'{'{KIND_OWN, 16'h8000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0}, 1'b0, '0},
		'{'{KIND_CAND, 16'h8000, 32'd0, 32'd0, 32'd5, 32'd5, 1'b0}, 1'b0, '0},
		'{'{KIND_CAND, 16'h7FFF, 32'd655359, 32'd0, PMAX, PMAX, 1'b0}, 1'b0, '0},
		'{'{KIND_CAND, 16'd1, 32'd655360, 32'd0, 32'd1, 32'd1, 1'b0}, 1'b0, '0},
		'{'{KIND_CAND, 16'd2, -32'sd655360, 32'd0, 32'd1, 32'd1, 1'b0}, 1'b0, '0},
		'{'{KIND_CAND, 16'd2, -32'sd655359, -32'sd655359, PMAX, PMIN, 1'b0}, 1'b0, '0},
		'{'{KIND_CAND, 16'd4, 32'd0, 32'd655360, 32'd9, 32'd9, 1'b1}, 1'b0, '0},
		// sums carry on past a result
		'{'{KIND_CAND, 16'd9, 32'd0, 32'd0, -32'sd7, -32'sd7, 1'b1}, 1'b0, '0},
		// negative sums truncate toward zero
		'{'{KIND_OWN, 16'd0, -32'sd3, -32'sd3, -32'sd3, 32'd3, 1'b0}, 1'b0, '0},
		'{'{KIND_CAND, 16'd1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1}, 1'b0, '0},
		'{'{KIND_OWN, 16'd100, PMIN, PMIN, PMIN, PMIN, 1'b0}, 1'b0, '0},
		'{'{KIND_CAND, 16'd101, PMIN + 32'd1, PMIN + 32'd1, PMIN, PMIN, 1'b0}, 1'b0, '0},
		'{'{KIND_CAND, 16'd102, PMIN, PMIN, PMIN, PMIN, 1'b1}, 1'b0, '0},
		'{'{KIND_OWN, 16'd5, PMAX, PMAX, PMAX, PMAX, 1'b0}, 1'b0, '0},
		'{'{KIND_CAND, 16'd6, PMAX, PMAX, PMAX, PMAX, 1'b0}, 1'b0, '0},
		'{'{KIND_CAND, 16'd7, PMAX - 32'd655359, PMAX, 32'd0, 32'd0, 1'b1}, 1'b0, '0},
		'{'{KIND_OWN, 16'd1, 32'd196608, -32'sd196608, 32'h1234_5678, 32'h0ABC_DEF0, 1'b1},
			1'b1, '{32'd196608, -32'sd196608, 32'h1234_5678, 32'h0ABC_DEF0, 7'd0, 1'b0}}
	};

	// model state
	logic [RANGE_W-1:0] box_range = RANGE_RESET;
	logic [ID_W-1:0]    own_id = '0;
	longint             own_px = 0, own_py = 0, own_vx = 0, own_vy = 0;
	longint             sum_px = 0, sum_py = 0, sum_vx = 0, sum_vy = 0;
	int                 nbr_count = 0;
	bit                 nbr_dropped = 1'b0;

	// expected averages in order, ring of PEND_DEPTH entries
	boid_result_t pend_avg [PEND_DEPTH];
	int  pend_wr = 0;
	int  pend_rd = 0;

	int  mismatch_count = 0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  full_sets = 0;
	int  ranges_used = 0;
	bit  sender_bursty = 1'b1;
	int  burst_left = 0;
	bit  hold_off_req = 1'b0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		$display("MISMATCH %0t %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	task automatic pend_put(input boid_result_t r);
		pend_avg[pend_wr % PEND_DEPTH] = r;
		pend_wr++;
	endtask

	function automatic bit in_box(input longint centre, input longint p);
		longint r;
		r = longint'(box_range);
		return (p > centre - r) && (p < centre + r);
	endfunction

	task automatic step_flock_model(input boid_item_t it, input bit typed,
			input boid_result_t typed_res);
		boid_result_t r;
		longint px, py, vx, vy, d;
		px = longint'($signed(it.px));
		py = longint'($signed(it.py));
		vx = longint'($signed(it.vx));
		vy = longint'($signed(it.vy));
		if (it.kind == KIND_OWN) begin
			own_id = it.id;
			own_px = px; own_py = py; own_vx = vx; own_vy = vy;
			sum_px = px; sum_py = py; sum_vx = vx; sum_vy = vy;
			nbr_count = 0;
			nbr_dropped = 1'b0;
		end else if (it.id != own_id && in_box(own_px, px) && in_box(own_py, py)) begin
			if (nbr_count < MAX_NEIGHBORS) begin
				sum_px += px; sum_py += py; sum_vx += vx; sum_vy += vy;
				nbr_count++;
			end else begin
				nbr_dropped = 1'b1;
			end
		end
		if (it.last) begin
			if (nbr_count > 0) begin
				d = longint'(nbr_count + 1);
				own_px = sum_px / d;
				own_py = sum_py / d;
				own_vx = sum_vx / d;
				own_vy = sum_vy / d;
			end
			r.npx = own_px[POS_W-1:0];
			r.npy = own_py[POS_W-1:0];
			r.nvx = own_vx[POS_W-1:0];
			r.nvy = own_vy[POS_W-1:0];
			r.cnt = NCOUNT_W'(nbr_count);
			r.dropped = nbr_dropped;
			pend_put(typed ? typed_res : r);
		end
	endtask

	task automatic send_item(input boid_item_t it, input bit typed, input boid_result_t want);
		int gap;
		if (!sender_bursty) begin
			gap = 0;
		end else if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tlast  <= it.last;
		s_tdata  <= IN_TDATA_W'({it.vy, it.vx, it.py, it.px, it.id});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		step_flock_model(it, typed, want);
	endtask

	// sender idle until every pending average is back and the block settled
	task automatic wait_all_averages();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pend_wr != pend_rd) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_box_range(input logic [RANGE_W-1:0] r);
		@(negedge clk);
		range_we    <= 1'b1;
		range_wdata <= r;
		@(negedge clk);
		range_we    <= 1'b0;
		box_range = r;
		ranges_used++;
	endtask

	function automatic logic [POS_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return PMAX;
			1: return PMIN;
			2, 3: return $urandom();
			default: return POS_W'($urandom_range(0, 1 << 21)) - POS_W'(1 << 20);
		endcase
	endfunction

	// coordinate inside the box around centre, now and then on its edge
	function automatic logic [POS_W-1:0] near_coord(input longint centre);
		longint lim, off;
		lim = (box_range > 1) ? longint'(box_range) - 1 : 0;
		if ($urandom_range(0, 9) == 0)
			off = longint'(box_range);
		else
			off = longint'($urandom_range(0, 32'(lim)));
		if ($urandom_range(0, 1))
			off = -off;
		return POS_W'(centre + off);
	endfunction

	task automatic send_flock_set(input int n_cand, input bit do_load);
		boid_item_t it;
		int k;
		if (do_load) begin
			it.kind = KIND_OWN;
			it.id   = ID_W'($urandom());
			it.px   = rand_coord();
			it.py   = rand_coord();
			it.vx   = rand_coord();
			it.vy   = rand_coord();
			it.last = (n_cand == 0);
			send_item(it, 1'b0, '0);
		end
		for (k = 0; k < n_cand; k++) begin
			it.kind = KIND_CAND;
			it.last = (k == n_cand - 1);
			it.vx   = rand_coord();
			it.vy   = rand_coord();
			case ($urandom_range(0, 19))
				0: begin
					it.id = own_id;
					it.px = near_coord(own_px);
					it.py = near_coord(own_py);
				end
				1, 2, 3: begin
					it.id = ID_W'($urandom());
					it.px = rand_coord();
					it.py = rand_coord();
				end
				default: begin
					it.id = own_id + ID_W'($urandom_range(1, 65535));
					it.px = near_coord(own_px);
					it.py = near_coord(own_py);
				end
			endcase
			send_item(it, 1'b0, '0);
		end
	endtask

	// receiver: stall patterns, plus one long hold-off on request
	initial begin
		int hold_cycles;
		int pat_left;
		int pat_mode;
		hold_cycles = 0;
		pat_left = 0;
		pat_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req && hold_cycles == 0) begin
				hold_off_req = 1'b0;
				hold_cycles = HOLD_OFF_CYCLES;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else begin
				if (pat_left == 0) begin
					pat_mode = $urandom_range(0, 3);
					pat_left = $urandom_range(8, 60);
				end
				pat_left--;
				case (pat_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 7) != 0);
					default: m_tready <= (pat_left % 4 != 0);
				endcase
			end
		end
	end

	task automatic check_average();
		boid_result_t got, want;
		got.npx     = m_tdata[0*POS_W +: POS_W];
		got.npy     = m_tdata[1*POS_W +: POS_W];
		got.nvx     = m_tdata[2*POS_W +: POS_W];
		got.nvy     = m_tdata[3*POS_W +: POS_W];
		got.cnt     = m_tdata[4*POS_W +: NCOUNT_W];
		got.dropped = m_tuser;
		results_seen++;
		if (got.dropped)
			full_sets++;
		if (pend_wr == pend_rd) begin
			report_mismatch("result with nothing pending", got.npx, 0);
			return;
		end
		want = pend_avg[pend_rd % PEND_DEPTH];
		pend_rd++;
		if (got.npx !== want.npx) report_mismatch("new_pos_x", got.npx, want.npx);
		if (got.npy !== want.npy) report_mismatch("new_pos_y", got.npy, want.npy);
		if (got.nvx !== want.nvx) report_mismatch("new_vel_x", got.nvx, want.nvx);
		if (got.nvy !== want.nvy) report_mismatch("new_vel_y", got.nvy, want.nvy);
		if (got.cnt !== want.cnt) report_mismatch("neighbor_count", got.cnt, want.cnt);
		if (got.dropped !== want.dropped) report_mismatch("dropped", got.dropped, want.dropped);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_average();
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		boid_item_t it;
		logic [RANGE_W-1:0] r;
		int i, ph, n, phase_start;
		bit did_hold, did_pause, do_load;
		did_hold = 1'b0;
		did_pause = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < N_DIR; i++)
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		// crowd around one boid: capacity fills, the rest are dropped
		it = '{KIND_OWN, 16'd50, 32'd0, 32'd0, 32'd640, -32'sd640, 1'b0};
		send_item(it, 1'b0, '0);
		for (i = 0; i < 70; i++) begin
			it = '{KIND_CAND, ID_W'(51 + i), POS_W'(i), -POS_W'(i), rand_coord(), rand_coord(),
				i == 69};
			send_item(it, 1'b0, '0);
		end

		for (ph = 0; ph < 8; ph++) begin
			wait_all_averages();
			case (ph)
				0: r = '0;
				1: r = 31'h7FFF_FFFF;
				2: r = 31'd1;
				3: r = RANGE_RESET;
				default: r = RANGE_W'($urandom_range(16, 1 << (8 + $urandom_range(0, 22))));
			endcase
			set_box_range(r);
			sender_bursty = (ph != 2 && ph != 5);
			phase_start = items_sent;
			while (items_sent - phase_start < 85) begin
				if (ph == 1 && !did_hold && items_sent - phase_start >= 20) begin
					hold_off_req = 1'b1;
					did_hold = 1'b1;
				end
				if (ph == 4 && !did_pause && items_sent - phase_start >= 50) begin
					wait_all_averages();
					did_pause = 1'b1;
				end
				case ($urandom_range(0, 19))
					0: n = $urandom_range(60, 80);
					1, 2, 3, 4, 5: n = $urandom_range(7, 20);
					default: n = $urandom_range(0, 6);
				endcase
				do_load = ($urandom_range(0, 9) != 0) || (n == 0);
				send_flock_set(n, do_load);
			end
		end

		wait_all_averages();
		repeat (200) @(posedge clk);
		$display("Run covered %0d requests, %0d averages (%0d with neighbors dropped)",
			items_sent, results_seen, full_sets);
		$display("Box range written %0d times, including zero and full scale", ranges_used);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
